@@ design/bcrpc_pkg.sv @@
`default_nettype none
package bcrpc_pkg;

    localparam int CHANNELS      = 4;
    localparam int COUNT_BITS    = 16;
    localparam int COLOURS       = 3;
    localparam int DUTY_BITS     = 16;
    localparam int ID_BITS       = 16;
    localparam int PHASE_BITS    = 15;
    localparam int BYTE_BITS     = 8;
    localparam int PIN_BITS      = 12;
    localparam int CHAN_OUT_BITS = 2;
    localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [ID_BITS-1:0]    ID_BASE_RST    = 16'h0100;
    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RST = 15'd21845;

    // register select is paddr[2]
    localparam logic REG_ID_BASE    = 1'b0;
    localparam logic REG_PHASE_STEP = 1'b1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [DUTY_BITS-1:0] t_duty;

    // classified request handed from the parser to the PWM engine
    typedef struct packed {
        logic            is_tick;
        logic            apply;
        logic [CH_W-1:0] chan;
        t_duty           red;
        t_duty           green;
        t_duty           blue;
    } t_cmd;

endpackage
`default_nettype wire

@@ design/bcrpc_if.sv @@
`default_nettype none
interface bcrpc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [bcrpc_pkg::BYTE_BITS-1:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface bcrpc_out_if;
    logic                               valid;
    logic                               ready;
    logic [bcrpc_pkg::PIN_BITS-1:0]      pwm_pins;
    logic                               frame_applied;
    logic [bcrpc_pkg::CHAN_OUT_BITS-1:0] applied_channel;

    modport source (output valid, output pwm_pins, output frame_applied,
                    output applied_channel, input ready);
    modport sink   (input valid, input pwm_pins, input frame_applied,
                    input applied_channel, output ready);
endinterface
`default_nettype wire

@@ design/byte_command_rgb_pwm_controller.sv @@
// Byte-command RGB PWM controller. Each request is either a received command
// byte or one PWM timer tick, and each produces exactly one response with the
// twelve pin levels after that request, plus a flag and channel number when
// the byte closed an 8-byte frame (id, red, green, blue, all big-endian)
// whose id lies in id_base..id_base+3. A zero lead byte is skipped, so a run
// of zeros resyncs the framing. New duties are pending until the colour
// group's count (tick counter minus 0, phase_step or 2*phase_step) wraps to
// zero; pins are active-low, high while the count is at or above the duty.
// One request is taken per cycle if the queue has room; responses are
// registered. The parser and the PWM engine are split by a 4-entry queue, so
// the input keeps flowing for four requests while the response side is
// stalled; else the engine retires one request per cycle. Registers (APB,
// byte address 0 id_base, 4 phase_step) should be written only while idle.
`default_nettype none
module byte_command_rgb_pwm_controller (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    bcrpc_in_if.sink                                    i_req,
    bcrpc_out_if.source                                 o_rsp,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [bcrpc_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  wire logic [bcrpc_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic      [bcrpc_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                        pready
);

    logic [bcrpc_pkg::ID_BITS-1:0]     r_id_base;
    logic [bcrpc_pkg::PHASE_BITS-1:0]  r_phase_step;
    logic                              w_push, w_full, w_pop, w_empty;
    bcrpc_pkg::t_cmd                   w_push_cmd, w_head_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == bcrpc_pkg::REG_PHASE_STEP)
                  ? bcrpc_pkg::APB_DATA_BITS'(r_phase_step)
                  : bcrpc_pkg::APB_DATA_BITS'(r_id_base);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_base    <= bcrpc_pkg::ID_BASE_RST;
            r_phase_step <= bcrpc_pkg::PHASE_STEP_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                bcrpc_pkg::REG_ID_BASE:    r_id_base    <= pwdata[bcrpc_pkg::ID_BITS-1:0];
                bcrpc_pkg::REG_PHASE_STEP: r_phase_step <= pwdata[bcrpc_pkg::PHASE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    bcrpc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_id_base (r_id_base),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    bcrpc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_head_cmd)
    );

    bcrpc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_cmd        (w_head_cmd),
        .o_pop        (w_pop),
        .i_phase_step (r_phase_step),
        .o_rsp        (o_rsp)
    );

endmodule
`default_nettype wire

@@ design/bcrpc_front.sv @@
`default_nettype none
module bcrpc_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    bcrpc_in_if.sink                            i_req,
    input  wire logic [bcrpc_pkg::ID_BITS-1:0]  i_id_base,
    input  wire logic                           i_full,
    output logic                                o_push,
    output bcrpc_pkg::t_cmd                     o_cmd
);

    localparam logic [2:0] PS_ID_HI    = 3'd0;
    localparam logic [2:0] PS_ID_LO    = 3'd1;
    localparam logic [2:0] PS_RED_HI   = 3'd2;
    localparam logic [2:0] PS_RED_LO   = 3'd3;
    localparam logic [2:0] PS_GREEN_HI = 3'd4;
    localparam logic [2:0] PS_GREEN_LO = 3'd5;
    localparam logic [2:0] PS_BLUE_HI  = 3'd6;
    localparam logic [2:0] PS_BLUE_LO  = 3'd7;

    logic [2:0]                      r_step, n_step;
    logic [bcrpc_pkg::ID_BITS-1:0]   r_id, n_id;
    bcrpc_pkg::t_duty                r_red, n_red;
    bcrpc_pkg::t_duty                r_green, n_green;
    bcrpc_pkg::t_duty                r_blue, n_blue;
    logic [bcrpc_pkg::ID_BITS-1:0]   w_rel;
    logic                            w_match;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    // modular distance, so ids near the top do not wrap onto channel 0
    assign w_rel   = r_id - i_id_base;
    assign w_match = (w_rel < bcrpc_pkg::ID_BITS'(bcrpc_pkg::CHANNELS));

    always_comb begin
        n_step  = r_step;
        n_id    = r_id;
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;

        o_cmd.is_tick = (i_req.operation == bcrpc_pkg::OP_TICK);
        o_cmd.apply   = 1'b0;
        o_cmd.chan    = w_rel[bcrpc_pkg::CH_W-1:0];
        o_cmd.red     = r_red;
        o_cmd.green   = r_green;
        o_cmd.blue    = {r_blue[7:0], i_req.rx_byte};

        if (i_req.operation == bcrpc_pkg::OP_BYTE) begin
            case (r_step)
                PS_ID_HI: begin
                    // zero lead byte keeps us here: resync
                    n_id   = bcrpc_pkg::ID_BITS'(i_req.rx_byte);
                    n_step = (i_req.rx_byte != '0) ? PS_ID_LO : PS_ID_HI;
                end
                PS_ID_LO: begin
                    n_id   = {r_id[7:0], i_req.rx_byte};
                    n_step = PS_RED_HI;
                end
                PS_RED_HI: begin
                    n_red  = bcrpc_pkg::DUTY_BITS'(i_req.rx_byte);
                    n_step = PS_RED_LO;
                end
                PS_RED_LO: begin
                    n_red  = {r_red[7:0], i_req.rx_byte};
                    n_step = PS_GREEN_HI;
                end
                PS_GREEN_HI: begin
                    n_green = bcrpc_pkg::DUTY_BITS'(i_req.rx_byte);
                    n_step  = PS_GREEN_LO;
                end
                PS_GREEN_LO: begin
                    n_green = {r_green[7:0], i_req.rx_byte};
                    n_step  = PS_BLUE_HI;
                end
                PS_BLUE_HI: begin
                    n_blue = bcrpc_pkg::DUTY_BITS'(i_req.rx_byte);
                    n_step = PS_BLUE_LO;
                end
                PS_BLUE_LO: begin
                    n_blue      = {r_blue[7:0], i_req.rx_byte};
                    o_cmd.apply = w_match;
                    n_step      = PS_ID_HI;
                end
                default: begin
                    n_step = PS_ID_HI;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= PS_ID_HI;
        end else if (o_push) begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_id    <= n_id;
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

endmodule
`default_nettype wire

@@ design/bcrpc_fifo.sv @@
`default_nettype none
module bcrpc_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire bcrpc_pkg::t_cmd i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output bcrpc_pkg::t_cmd      o_data
);

    localparam int AW = bcrpc_pkg::FIFO_AW;
    localparam logic [AW-1:0] LAST = AW'(bcrpc_pkg::FIFO_DEPTH - 1);

    bcrpc_pkg::t_cmd  r_mem [bcrpc_pkg::FIFO_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == (AW+1)'(bcrpc_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ design/bcrpc_back.sv @@
`default_nettype none
module bcrpc_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_empty,
    input  wire bcrpc_pkg::t_cmd                   i_cmd,
    output logic                                   o_pop,
    input  wire logic [bcrpc_pkg::PHASE_BITS-1:0]  i_phase_step,
    bcrpc_out_if.source                            o_rsp
);

    localparam int NC = bcrpc_pkg::COLOURS;
    localparam int NCH = bcrpc_pkg::CHANNELS;
    localparam int CB = bcrpc_pkg::COUNT_BITS;

    logic [CB-1:0]     r_tick, n_tick;
    bcrpc_pkg::t_duty  r_pend [NC][NCH];
    bcrpc_pkg::t_duty  r_act  [NC][NCH];
    bcrpc_pkg::t_duty  n_act  [NC][NCH];
    logic [CB-1:0]     w_off  [NC];
    logic [CB-1:0]     w_cnt  [NC];
    logic [NC-1:0]     w_wrap;
    logic [bcrpc_pkg::PIN_BITS-1:0] w_pins;

    logic                                  r_valid;
    logic [bcrpc_pkg::PIN_BITS-1:0]        r_pins;
    logic                                  r_applied;
    logic [bcrpc_pkg::CHAN_OUT_BITS-1:0]   r_chan;

    assign o_pop = !i_empty && (!r_valid || o_rsp.ready);

    assign o_rsp.valid           = r_valid;
    assign o_rsp.pwm_pins        = r_pins;
    assign o_rsp.frame_applied   = r_applied;
    assign o_rsp.applied_channel = r_chan;

    assign w_off[0] = '0;
    assign w_off[1] = CB'(i_phase_step);
    assign w_off[2] = CB'({i_phase_step, 1'b0});

    assign n_tick = i_cmd.is_tick ? r_tick + 1'b1 : r_tick;

    // preload: a group takes its pending duties when its own count wraps to 0
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            w_cnt[c]  = n_tick - w_off[c];
            w_wrap[c] = i_cmd.is_tick && (w_cnt[c] == '0);
            for (int ch = 0; ch < NCH; ch++) begin
                n_act[c][ch] = w_wrap[c] ? r_pend[c][ch] : r_act[c][ch];
            end
        end
    end

    // active-low pins: high while count is at or above duty
    for (genvar b = 0; b < bcrpc_pkg::PIN_BITS; b++) begin : g_pin
        if (b / NCH < NC) begin : g_on
            assign w_pins[b] = (bcrpc_pkg::DUTY_BITS'(w_cnt[b / NCH]) >=
                                n_act[b / NCH][b % NCH]);
        end else begin : g_off
            assign w_pins[b] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            for (int c = 0; c < NC; c++) begin
                for (int ch = 0; ch < NCH; ch++) begin
                    r_pend[c][ch] <= '0;
                    r_act[c][ch]  <= '0;
                end
            end
        end else if (o_pop) begin
            r_tick <= n_tick;
            for (int c = 0; c < NC; c++) begin
                for (int ch = 0; ch < NCH; ch++) begin
                    r_act[c][ch] <= n_act[c][ch];
                end
            end
            for (int ch = 0; ch < NCH; ch++) begin
                if (i_cmd.apply && i_cmd.chan == bcrpc_pkg::CH_W'(ch)) begin
                    r_pend[0][ch] <= i_cmd.red;
                    r_pend[1][ch] <= i_cmd.green;
                    r_pend[2][ch] <= i_cmd.blue;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pins    <= w_pins;
            r_applied <= i_cmd.apply;
            r_chan    <= i_cmd.apply ? bcrpc_pkg::CHAN_OUT_BITS'(i_cmd.chan) : '0;
        end
    end

endmodule
`default_nettype wire

@@ design/bcrpc_chk.sv @@
`default_nettype none
module bcrpc_chk (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_out_valid,
    input wire logic                                  i_out_ready,
    input wire logic [bcrpc_pkg::PIN_BITS-1:0]        i_pins,
    input wire logic                                  i_applied,
    input wire logic [bcrpc_pkg::CHAN_OUT_BITS-1:0]   i_chan
);

    a_rst_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    a_chan_zero_unapplied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_applied |-> i_chan == '0)
        else $error("channel nonzero without applied frame");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_pins) && $stable(i_applied) && $stable(i_chan))
        else $error("response changed while stalled");

endmodule

bind byte_command_rgb_pwm_controller bcrpc_chk u_bcrpc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_pins      (o_rsp.pwm_pins),
    .i_applied   (o_rsp.frame_applied),
    .i_chan      (o_rsp.applied_channel)
);
`default_nettype wire
